// ----- src/alr_pkg.sv -----
package alr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 1024;

  localparam int COORD_W = 13;
  localparam int POS_W   = 14;
  localparam int ADDR_W  = 21;
  localparam int COLOR_W = 24;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int DVD_W = 31;
  localparam int DVS_W = 15;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd31;

  localparam int MUL_W = 18;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH = 3'd4;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- src/alr_ifs.sv -----
interface alr_req_if;
  import alr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface alr_pix_if;
  import alr_pkg::*;
  logic               valid;
  logic               ready;
  logic               near_valid;
  logic [ADDR_W-1:0]  near_address;
  logic [COLOR_W-1:0] near_color;
  logic               far_valid;
  logic [ADDR_W-1:0]  far_address;
  logic [COLOR_W-1:0] far_color;
  logic               last_column;
  modport source (output valid, near_valid, near_address, near_color, far_valid,
                  far_address, far_color, last_column, input ready);
  modport sink (input valid, near_valid, near_address, near_color, far_valid,
                far_address, far_color, last_column, output ready);
endinterface

interface alr_cfg_if;
  import alr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/antialiased_line_rasterizer.sv -----
// Wu-style antialiased line engine. A load transaction takes two endpoints,
// applies the offsets, picks the major axis and divides once for the slope
// in a bit-serial divider of 31 steps, and takes no further request until
// it is done. Each tick transaction then draws one column and returns one
// pixel transaction with up to two writes; the single shared 18x18
// multiplier computes the address product, the far-write bound and the six
// channel blends in turn. Ticks while no line is active return nothing.
// Config writes are accepted at any time and should be issued only while
// the block is idle.
module antialiased_line_rasterizer import alr_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input logic   clk,
  input logic   rst,
  alr_req_if.sink   req,
  alr_cfg_if.sink   cfg,
  alr_pix_if.source pix
);

  localparam logic [POS_W-1:0] LIM_W = POS_W'(SCREEN_WIDTH);
  localparam logic [POS_W-1:0] LIM_H = POS_W'(SCREEN_HEIGHT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LMUL = 3'd2;
  localparam logic [2:0] S_LFIN = 3'd3;
  localparam logic [2:0] S_ADR  = 3'd4;
  localparam logic [2:0] S_TOP  = 3'd5;
  localparam logic [2:0] S_BLD  = 3'd6;

  // config registers
  logic [COLOR_W-1:0]        fg_color, bg_color;
  logic signed [COORD_W-1:0] offset_x, offset_y;
  logic [11:0]               row_pitch;

  // line state
  logic [2:0]              state;
  logic                    line_active, steep_mode, span_nonzero, rise_nonzero;
  logic [POS_W-1:0]        column_now;
  logic signed [POS_W-1:0] column_end;
  logic [ACC_W-1:0]        intercept_acc, slope_step;

  // load working registers
  logic signed [POS_W-1:0] ld_x1, ld_y1;
  logic                    ld_neg;
  logic signed [MUL_W-1:0] slope_q;

  // tick working registers
  logic signed [FRAC_W-1:0] t_row;
  logic [FRAC_W-1:0]        t_frac;
  logic                     t_inwin, t_edge, far_ok;
  logic [26:0]              na, fa;
  logic [2:0]               bidx;
  logic [47:0]              blend_buf;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  // output register
  logic               out_valid;
  logic               o_near_valid, o_far_valid, o_last;
  logic [ADDR_W-1:0]  o_near_address, o_far_address;
  logic [COLOR_W-1:0] o_near_color, o_far_color;

  // load front end
  logic signed [POS_W-1:0] sx1, sy1, sx2, sy2, a1, b1, a2, b2, p1, q1, p2, q2;
  logic signed [POS_W:0]   dxr, dyr, adx, ady, dx, dy, ady2;
  logic                    steep_in;

  always_comb begin
    sx1 = {req.start_x[COORD_W-1], req.start_x} + {offset_x[COORD_W-1], offset_x};
    sy1 = {req.start_y[COORD_W-1], req.start_y} + {offset_y[COORD_W-1], offset_y};
    sx2 = {req.end_x[COORD_W-1], req.end_x} + {offset_x[COORD_W-1], offset_x};
    sy2 = {req.end_y[COORD_W-1], req.end_y} + {offset_y[COORD_W-1], offset_y};
    dxr = {sx2[POS_W-1], sx2} - {sx1[POS_W-1], sx1};
    dyr = {sy2[POS_W-1], sy2} - {sy1[POS_W-1], sy1};
    adx = dxr[POS_W] ? -dxr : dxr;
    ady = dyr[POS_W] ? -dyr : dyr;
    steep_in = ady > adx;
    a1 = steep_in ? sy1 : sx1;
    b1 = steep_in ? sx1 : sy1;
    a2 = steep_in ? sy2 : sx2;
    b2 = steep_in ? sx2 : sy2;
    if (a1 > a2) begin
      p1 = a2; q1 = b2; p2 = a1; q2 = b1;
    end else begin
      p1 = a1; q1 = b1; p2 = a2; q2 = b2;
    end
    dx   = {p2[POS_W-1], p2} - {p1[POS_W-1], p1};
    dy   = {q2[POS_W-1], q2} - {q1[POS_W-1], q1};
    ady2 = dy[POS_W] ? -dy : dy;
  end

  // divider
  div_ctl_t         div_ctl;
  logic [DVD_W-1:0] div_q;
  logic             load_acc, tick_acc;

  assign load_acc      = req.valid && req.ready && (req.req_type == REQ_LOAD);
  assign tick_acc      = req.valid && req.ready && (req.req_type == REQ_TICK);
  assign div_ctl.start = load_acc;

  alr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend ({ady2[DVS_W-1:0], {FRAC_W{1'b0}}}),
    .divisor  (dx[DVS_W-1:0]),
    .done     (div_ctl.done),
    .quotient (div_q)
  );

  // blend channel selection
  logic [1:0]          ch;
  logic [7:0]          fg_ch, bg_ch, bg_prev;
  logic [16:0]         cov;
  logic signed [8:0]   cdiff;
  logic [2:0]          pidx;
  logic [1:0]          pch;
  logic [7:0]          byte_res;

  always_comb begin
    ch    = (bidx < 3'd3) ? bidx[1:0] : 2'(bidx - 3'd3);
    fg_ch = fg_color[8*ch +: 8];
    bg_ch = bg_color[8*ch +: 8];
    cov   = (bidx < 3'd3) ? 17'(17'h10000 - {1'b0, t_frac}) : {1'b0, t_frac};
    cdiff = $signed({1'b0, fg_ch}) - $signed({1'b0, bg_ch});
    pidx  = bidx - 3'd1;
    pch   = (pidx < 3'd3) ? pidx[1:0] : 2'(pidx - 3'd3);
    bg_prev  = bg_color[8*pch +: 8];
    byte_res = bg_prev + prod[23:16];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LMUL: begin
        mul_a = slope_q;
        mul_b = MUL_W'(ld_x1);
      end
      S_ADR: begin
        mul_a = steep_mode ? $signed({4'b0, column_now}) : MUL_W'(t_row);
        mul_b = $signed({6'b0, row_pitch});
      end
      S_TOP: begin
        mul_a = $signed({6'b0, row_pitch});
        mul_b = MUL_W'(SCREEN_HEIGHT);
      end
      S_BLD: begin
        mul_a = MUL_W'(cdiff);
        mul_b = $signed({1'b0, cov});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // tick address terms
  logic [26:0]       na_c;
  logic [POS_W-1:0]  lim, col_inc;
  logic [POS_W:0]    col_inc_w;
  logic              out_free;
  logic              emit;

  always_comb begin
    na_c      = prod[26:0] + (steep_mode ? 27'(t_row[12:0]) : 27'(column_now));
    lim       = steep_mode ? LIM_H : LIM_W;
    col_inc_w = {1'b0, column_now} + 1'b1;
    col_inc   = col_inc_w[POS_W-1:0];
    out_free  = !out_valid || pix.ready;
    emit      = (state == S_BLD) && (bidx == 3'd7) && out_free;
  end

  // config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color  <= 24'hFFFFFF;
      bg_color  <= '0;
      offset_x  <= '0;
      offset_y  <= '0;
      row_pitch <= 12'd1024;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FG_COLOR:  fg_color  <= cfg.data;
        CFG_BG_COLOR:  bg_color  <= cfg.data;
        CFG_OFFSET_X:  offset_x  <= cfg.data[COORD_W-1:0];
        CFG_OFFSET_Y:  offset_y  <= cfg.data[COORD_W-1:0];
        CFG_ROW_PITCH: row_pitch <= cfg.data[11:0];
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  // sequencer
  logic signed [ACC_W-1:0] icpt;
  logic [POS_W-1:0]        start_col;

  always_comb begin
    icpt = {{(ACC_W-POS_W-FRAC_W){ld_y1[POS_W-1]}}, ld_y1, {FRAC_W{1'b0}}};
    if (ld_x1 < 0) begin
      icpt = icpt - prod[ACC_W-1:0];
    end
    start_col = (ld_x1 > 0) ? ld_x1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      line_active   <= 1'b0;
      steep_mode    <= 1'b0;
      span_nonzero  <= 1'b0;
      rise_nonzero  <= 1'b0;
      column_now    <= '0;
      column_end    <= '0;
      intercept_acc <= '0;
      slope_step    <= '0;
      out_valid     <= 1'b0;
      bidx          <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load_acc) begin
            steep_mode   <= steep_in;
            span_nonzero <= dx != 0;
            rise_nonzero <= dy != 0;
            ld_x1        <= p1;
            ld_y1        <= q1;
            column_end   <= p2;
            ld_neg       <= dy[POS_W];
            state        <= S_DIV;
          end else if (tick_acc && line_active) begin
            t_row  <= intercept_acc[ACC_W-1:FRAC_W];
            t_frac <= intercept_acc[FRAC_W-1:0];
            state  <= S_ADR;
          end
        end
        S_DIV: begin
          if (div_ctl.done) begin
            if (!span_nonzero) begin
              slope_q <= '0;
            end else if (ld_neg) begin
              slope_q <= -$signed(div_q[MUL_W-1:0]);
            end else begin
              slope_q <= $signed(div_q[MUL_W-1:0]);
            end
            state <= S_LMUL;
          end
        end
        S_LMUL: begin
          state <= S_LFIN;
        end
        S_LFIN: begin
          slope_step    <= ACC_W'(slope_q);
          intercept_acc <= icpt;
          column_now    <= start_col;
          line_active   <= ($signed(start_col) <= column_end) && (start_col < lim);
          state         <= S_IDLE;
        end
        S_ADR: begin
          t_inwin <= !t_row[FRAC_W-1] &&
                     (t_row[14:0] < 15'(steep_mode ? SCREEN_WIDTH : SCREEN_HEIGHT));
          t_edge  <= steep_mode && (t_row[14:0] >= 15'(SCREEN_WIDTH - 1));
          state   <= S_TOP;
        end
        S_TOP: begin
          na    <= na_c;
          fa    <= na_c + (steep_mode ? 27'd1 : 27'(row_pitch));
          bidx  <= '0;
          state <= S_BLD;
        end
        S_BLD: begin
          if (bidx == 3'd0) begin
            far_ok <= fa < prod[26:0];
            bidx   <= bidx + 1'b1;
          end else if (bidx != 3'd7) begin
            blend_buf[8*pidx +: 8] <= byte_res;
            bidx <= bidx + 1'b1;
          end else if (out_free) begin
            o_near_valid   <= t_inwin && span_nonzero;
            o_near_address <= (t_inwin && span_nonzero) ? na[ADDR_W-1:0] : '0;
            o_near_color   <= (t_inwin && span_nonzero) ? blend_buf[23:0] : '0;
            o_far_valid    <= t_inwin && rise_nonzero && far_ok && !t_edge;
            o_far_address  <= (t_inwin && rise_nonzero && far_ok && !t_edge) ?
                              fa[ADDR_W-1:0] : '0;
            o_far_color    <= (t_inwin && rise_nonzero && far_ok && !t_edge) ?
                              blend_buf[47:24] : '0;
            o_last         <= ($signed(column_now) == column_end) || (col_inc_w >= {1'b0, lim});
            intercept_acc  <= intercept_acc + slope_step;
            column_now     <= col_inc;
            line_active    <= ($signed(col_inc) <= column_end) && (col_inc_w < {1'b0, lim});
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pix.valid        = out_valid;
  assign pix.near_valid   = o_near_valid;
  assign pix.near_address = o_near_address;
  assign pix.near_color   = o_near_color;
  assign pix.far_valid    = o_far_valid;
  assign pix.far_address  = o_far_address;
  assign pix.far_color    = o_far_color;
  assign pix.last_column  = o_last;

  a_load_to_div: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> state == S_DIV)
    else $error("load did not start the divide");

  a_out_from_blend: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_BLD)
    else $error("pixel transaction raised outside the blend step");

  a_near_zeroed: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.near_valid) |-> (pix.near_address == '0 && pix.near_color == '0))
    else $error("suppressed near write carries data");

  a_far_zeroed: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.far_valid) |-> (pix.far_address == '0 && pix.far_color == '0))
    else $error("suppressed far write carries data");

endmodule

// ----- src/alr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module alr_div import alr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVD_W-1:0]     dvd;
  logic [DVS_W:0]       trial;
  logic                 qbit;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    qbit  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_STEPS;
      rem  <= '0;
      dvs  <= divisor;
      dvd  <= dividend;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        rem <= qbit ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], qbit};
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign done     = busy && (cnt == '0);
  assign quotient = dvd;

endmodule

// ----- dv/tb_antialiased_line_rasterizer.sv -----
`timescale 1ns / 100ps

// Line engine testbench: directed rows first, then random line loads,
// each followed by a burst of column ticks. A local model of the engine
// predicts every pixel transaction; results are compared in order.
module tb_antialiased_line_rasterizer;
  import alr_pkg::*;

  localparam int SW = SCREEN_WIDTH_DEF;
  localparam int SH = SCREEN_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM = 1930;
  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

  logic clk;
  logic rst;

  alr_req_if req ();
  alr_cfg_if cfg ();
  alr_pix_if pix ();

  antialiased_line_rasterizer dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .cfg(cfg.sink),
    .pix(pix.source)
  );

  typedef struct packed {
    logic               near_valid;
    logic [ADDR_W-1:0]  near_address;
    logic [COLOR_W-1:0] near_color;
    logic               far_valid;
    logic [ADDR_W-1:0]  far_address;
    logic [COLOR_W-1:0] far_color;
    logic               last_column;
  } pixel_pair_t;

  typedef struct {
    logic                      kind;
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    logic                      has_known;
    pixel_pair_t               known;
  } stim_row_t;

  // predictor state: registers
  logic [23:0] fg_q, bg_q;
  int          offx_q, offy_q;
  int          pitch_q;
  // predictor state: line walker
  bit          active_q, steep_q, span_q, rise_q;
  int          col_now_q, col_end_q;
  logic [31:0] acc_q, slope_q;

  pixel_pair_t pending_pixels[$];
  int  errors;
  int  mismatch_count;
  int  results_seen;
  longint cycle_count;
  bit  hold_off;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [23:0] mix_color(longint cov);
    logic [23:0] res;
    longint f, b;
    res = '0;
    for (int sh = 0; sh <= 16; sh += 8) begin
      f = (fg_q >> sh) & 8'hff;
      b = (bg_q >> sh) & 8'hff;
      res |= 24'(((f * cov + b * (65536 - cov)) >> 16) & 8'hff) << sh;
    end
    return res;
  endfunction

  // update the line walker from a load transaction
  task automatic start_line(int ax, int ay, int bx, int by);
    int x1, y1, x2, y2, t, adx, ady, dx, dy;
    longint slope, icpt;
    x1 = ax + offx_q; y1 = ay + offy_q;
    x2 = bx + offx_q; y2 = by + offy_q;
    adx = x2 > x1 ? x2 - x1 : x1 - x2;
    ady = y2 > y1 ? y2 - y1 : y1 - y2;
    steep_q = ady > adx;
    if (steep_q) begin
      t = x1; x1 = y1; y1 = t;
      t = x2; x2 = y2; y2 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    dx = x2 - x1;
    dy = y2 - y1;
    span_q = dx != 0;
    rise_q = dy != 0;
    slope = dx != 0 ? (longint'(dy) * 65536) / dx : 0;
    icpt = longint'(y1) * 65536;
    if (x1 < 0) icpt -= slope * x1;
    slope_q = slope[31:0];
    acc_q = icpt[31:0];
    col_now_q = x1 > 0 ? x1 : 0;
    col_end_q = x2;
    active_q = col_now_q <= col_end_q && col_now_q < (steep_q ? SH : SW);
  endtask

  // one column; returns 1 when a pixel transaction is due
  function automatic bit step_column(output pixel_pair_t p);
    int lim, rows, row;
    longint frac, col, na, fa;
    bit nv, fv;
    p = '0;
    if (!active_q) return 0;
    lim = steep_q ? SH : SW;
    rows = steep_q ? SW : SH;
    row = $signed(acc_q[31:16]);
    frac = acc_q[15:0];
    col = col_now_q;
    nv = row >= 0 && row < rows && span_q;
    fv = row >= 0 && row < rows && rise_q;
    if (steep_q) begin
      na = row + col * pitch_q;
      fa = longint'(row) + 1 + col * pitch_q;
      if (row + 1 >= SW) fv = 0;
    end else begin
      na = col + longint'(row) * pitch_q;
      fa = col + (longint'(row) + 1) * pitch_q;
    end
    if (fa >= longint'(pitch_q) * SH) fv = 0;
    if (nv) begin
      p.near_valid = 1;
      p.near_address = na[ADDR_W-1:0];
      p.near_color = mix_color(65536 - frac);
    end
    if (fv) begin
      p.far_valid = 1;
      p.far_address = fa[ADDR_W-1:0];
      p.far_color = mix_color(frac);
    end
    p.last_column = col_now_q == col_end_q || col_now_q + 1 >= lim;
    acc_q += slope_q;
    col_now_q++;
    active_q = col_now_q <= col_end_q && col_now_q < lim;
    return 1;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_FG_COLOR:  fg_q = val;
      CFG_BG_COLOR:  bg_q = val;
      CFG_OFFSET_X:  offx_q = $signed(val[12:0]);
      CFG_OFFSET_Y:  offy_q = $signed(val[12:0]);
      CFG_ROW_PITCH: pitch_q = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // wait for all results, then let a tick in flight drain
  task automatic drain();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // send one request; expected result from the predictor unless given
  task automatic send_req(stim_row_t r, int gap);
    pixel_pair_t p;
    bit due;
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid    <= 1'b1;
    req.req_type <= r.kind;
    req.start_x  <= r.sx;
    req.start_y  <= r.sy;
    req.end_x    <= r.ex;
    req.end_y    <= r.ey;
    do @(posedge clk); while (!req.ready);
    if (r.kind == REQ_LOAD) begin
      start_line(r.sx, r.sy, r.ex, r.ey);
    end else begin
      due = step_column(p);
      if (due) pending_pixels.push_back(r.has_known ? r.known : p);
    end
  endtask

  task automatic idle_req();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // result side: random back-pressure plus the long hold-off
  initial begin
    pix.ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) pix.ready <= 1'b0;
      else pix.ready <= ($urandom_range(0, 3) != 0) ||
                        ($urandom_range(0, 1) == 0 && cycle_count[9]);
    end
  end

  // results checked in order against the expectation queue
  always @(posedge clk) begin
    pixel_pair_t got, exp_p;
    if (!rst && pix.valid && pix.ready) begin
      got = '{pix.near_valid, pix.near_address, pix.near_color,
              pix.far_valid, pix.far_address, pix.far_color, pix.last_column};
      results_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (mismatch_count++ < 10) $display("unexpected pixel transaction %p", got);
      end else begin
        exp_p = pending_pixels.pop_front();
        if (got !== exp_p) begin
          errors++;
          if (mismatch_count++ < 10)
            $display("pixel mismatch: expected %p got %p", exp_p, got);
        end
      end
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t mk(logic k, int a, int b, int c, int d);
    stim_row_t r;
    r.kind = k;
    r.sx = COORD_W'(a); r.sy = COORD_W'(b); r.ex = COORD_W'(c); r.ey = COORD_W'(d);
    r.has_known = 0; r.known = '0;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    int ncols;
    errors = 0; mismatch_count = 0; results_seen = 0; hold_off = 0; hold_done = 0;
    rst = 1'b1;
    req.valid = 0; req.req_type = REQ_TICK;
    req.start_x = 0; req.start_y = 0; req.end_x = 0; req.end_y = 0;
    cfg.valid = 0; cfg.index = CFG_FG_COLOR; cfg.data = 0;
    fg_q = 24'hffffff; bg_q = 0; offx_q = 0; offy_q = 0; pitch_q = 1024;
    active_q = 0; steep_q = 0; span_q = 0; rise_q = 0;
    col_now_q = 0; col_end_q = 0; acc_q = 0; slope_q = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: tick while idle, a point, horizontal, steep, clipped,
    // off-screen and extreme coordinates
    directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));                // idle tick: nothing
    directed.push_back(mk(REQ_LOAD, 5, 7, 5, 7));                // single point
    r = mk(REQ_TICK, 0, 0, 0, 0);
    r.has_known = 1;
    r.known = '{1'b0, '0, '0, 1'b0, '0, '0, 1'b1};               // both writes suppressed
    directed.push_back(r);
    directed.push_back(mk(REQ_LOAD, 0, 3, 2, 3));                // horizontal
    r = mk(REQ_TICK, 0, 0, 0, 0);
    r.has_known = 1;
    r.known = '{1'b1, 21'd3072, 24'hffffff, 1'b0, '0, '0, 1'b0}; // full coverage
    directed.push_back(r);
    directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LOAD, 3, 0, 1, 6));                // steep, reversed
    repeat (4) directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LOAD, -4096, -4096, 4095, 4095));  // clipped diagonal
    repeat (3) directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LOAD, 4095, -4096, -4096, 4095));
    repeat (2) directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LOAD, 1020, 1023, 1030, 1024));    // right/bottom edge
    repeat (5) directed.push_back(mk(REQ_TICK, 0, 0, 0, 0));
    foreach (directed[i]) send_req(directed[i], 0);
    idle_req();
    drain();

    // random part in phases with different register settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(CFG_FG_COLOR, 24'h000000); write_reg(CFG_BG_COLOR, 24'hffffff);
          write_reg(CFG_ROW_PITCH, 24'd1);
        end
        2: begin
          write_reg(CFG_FG_COLOR, 24'($urandom)); write_reg(CFG_BG_COLOR, 24'($urandom));
          write_reg(CFG_OFFSET_X, 24'h1000); write_reg(CFG_OFFSET_Y, 24'h0fff);
          write_reg(CFG_ROW_PITCH, 24'd2048);
        end
        3: begin
          write_reg(CFG_OFFSET_X, 24'h0fff); write_reg(CFG_OFFSET_Y, 24'h1000);
          write_reg(CFG_ROW_PITCH, 24'd4095);
        end
        4: begin
          write_reg(CFG_OFFSET_X, 24'($urandom_range(0, 8191)));
          write_reg(CFG_OFFSET_Y, 24'($urandom_range(0, 8191)));
          write_reg(CFG_ROW_PITCH, 24'($urandom_range(1, 2048)));
          write_reg(CFG_UNUSED, 24'($urandom));
        end
        default: begin
          write_reg(CFG_OFFSET_X, 24'd0); write_reg(CFG_OFFSET_Y, 24'd0);
          write_reg(CFG_FG_COLOR, 24'($urandom)); write_reg(CFG_BG_COLOR, 24'($urandom));
          write_reg(CFG_ROW_PITCH, 24'd1024);
        end
      endcase
      for (int n = 0; n < N_RANDOM / 6; ) begin
        // mostly on-screen loads; sometimes anywhere in the field range
        if ($urandom_range(0, 4) == 0)
          r = mk(REQ_LOAD, $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                 $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
        else
          r = mk(REQ_LOAD, $urandom_range(0, 1100) - 40, $urandom_range(0, 1100) - 40,
                 $urandom_range(0, 1100) - 40, $urandom_range(0, 1100) - 40);
        send_req(r, short_gap());
        n++;
        ncols = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(1, 12);
        // long result hold-off while ticks keep coming in
        if (phase == 2 && n >= 10 && !hold_done) begin
          hold_done = 1;
          hold_off = 1;
          fork
            begin
              repeat (300) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        for (int k = 0; k < ncols; k++) begin
          r = mk(REQ_TICK, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 8191), $urandom_range(0, 8191));
          send_req(r, ($urandom_range(0, 4) == 0) ? short_gap() : 0);
          n++;
        end
        if (n % 97 == 0) begin
          idle_req();
          while (pending_pixels.size() != 0) @(posedge clk);
        end
      end
      idle_req();
      drain();
    end

    $display("covered directed edge lines, %0d pixel transactions over six register",
             results_seen);
    $display("settings with random endpoints, gaps and result back-pressure");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors, %0d results left", errors, pending_pixels.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
